/* sv/wav_riff_parser_pcm16_unit_assert.svh */
// Assertion macros for the WAV parser back end.
`ifndef WAV_RIFF_PARSER_PCM16_UNIT_ASSERT_SVH
`define WAV_RIFF_PARSER_PCM16_UNIT_ASSERT_SVH

// Same-cycle implication under the synchronous reset.
`define WRP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the synchronous reset.
`define WRP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/wrp_pkg.sv */
// Types and constants shared by the WAV parser modules.
package wrp_pkg;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_of_file;
        logic       end_of_file;
    } wrp_in_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample;
        logic [1:0]         channel_count;
        logic [31:0]        sample_rate;
        logic [15:0]        source_bits;
        logic [2:0]         error_code;
        logic               last;
    } wrp_out_t;

    typedef enum logic [3:0] {
        PH_RIFF_TAG,
        PH_RIFF_LEN,
        PH_WAVE_TAG,
        PH_CHUNK_ID,
        PH_CHUNK_LEN,
        PH_FMT,
        PH_SKIP,
        PH_DATA,
        PH_DONE,
        PH_HALT
    } phase_t;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NOT_RIFF  = 3'd1;
    localparam logic [2:0] ERR_NOT_WAVE  = 3'd2;
    localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
    localparam logic [2:0] ERR_BAD_DEPTH = 3'd4;
    localparam logic [2:0] ERR_EARLY_END = 3'd5;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [4:0]  TAG_BYTES         = 5'd4;
    localparam logic [4:0]  FMT_CAPTURE_BYTES = 5'd18;
    localparam logic [15:0] MAX_CHANNELS      = 16'd2;
    localparam logic [7:0]  PCM_OFFSET        = 8'h80;

endpackage

/* sv/wrp_front.sv */
// Input side: accepts byte transfers into a short queue ahead of the parser.
module wrp_front
    import wrp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  wrp_in_t s_data,
    output logic    q_valid,
    input  logic    q_ready,
    output wrp_in_t q_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    wrp_in_t          mem [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign s_ready = (count_reg != FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + IDX_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + IDX_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/wrp_parser.sv */
// Back end: RIFF/WAVE chunk walker, PCM converter and result register.
`include "wav_riff_parser_pcm16_unit_assert.svh"
module wrp_parser
    import wrp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  wrp_in_t  in_data,
    output logic     m_valid,
    input  logic     m_ready,
    output wrp_out_t m_data
);

    phase_t      phase_reg, phase_next, cur_phase;
    logic [31:0] tag_reg, tag_next, cur_tag;
    logic [31:0] len_reg, len_next, cur_len;
    logic [31:0] left_reg, left_next, cur_left;
    logic [15:0] fmt_tag_reg, fmt_tag_next, cur_fmt_tag;
    logic [15:0] chan_reg, chan_next, cur_chan;
    logic [31:0] rate_reg, rate_next, cur_rate;
    logic [15:0] bits_reg, bits_next, cur_bits;
    logic [4:0]  field_index_reg, field_index_next, cur_fidx;
    logic [7:0]  asm_reg, asm_next;
    logic [1:0]  sbi_reg, sbi_next, cur_sbi;
    logic        m_valid_reg, m_valid_next;
    wrp_out_t    m_data_reg, m_data_next;

    logic        step, emit, fmt_err, done, lst, empty;
    logic [7:0]  b;
    logic [4:0]  fidx_inc;
    logic [31:0] tag_new, len_new, left_dec;
    logic [1:0]  bps;
    logic [15:0] smp;
    wrp_out_t    res;

    assign in_ready = !m_valid_reg || m_ready;
    assign step     = in_valid && in_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign b        = in_data.file_byte;

    always_comb begin
        if (in_data.first_of_file) begin
            cur_phase   = PH_RIFF_TAG;
            cur_tag     = '0;
            cur_len     = '0;
            cur_left    = '0;
            cur_fmt_tag = '0;
            cur_chan    = '0;
            cur_rate    = '0;
            cur_bits    = '0;
            cur_fidx    = '0;
            cur_sbi     = '0;
        end else begin
            cur_phase   = phase_reg;
            cur_tag     = tag_reg;
            cur_len     = len_reg;
            cur_left    = left_reg;
            cur_fmt_tag = fmt_tag_reg;
            cur_chan    = chan_reg;
            cur_rate    = rate_reg;
            cur_bits    = bits_reg;
            cur_fidx    = field_index_reg;
            cur_sbi     = sbi_reg;
        end
    end

    always_comb begin
        fidx_inc = cur_fidx + 5'd1;
        tag_new  = {cur_tag[23:0], b};
        len_new  = {b, cur_len[31:8]};
        left_dec = cur_left - 32'd1;
        bps      = cur_bits[4:3];
        empty    = len_new < {30'd0, bps};
        lst      = left_dec < {30'd0, bps};

        phase_next       = cur_phase;
        tag_next         = cur_tag;
        len_next         = cur_len;
        left_next        = cur_left;
        fmt_tag_next     = cur_fmt_tag;
        chan_next        = cur_chan;
        rate_next        = cur_rate;
        bits_next        = cur_bits;
        field_index_next = cur_fidx;
        asm_next         = asm_reg;
        sbi_next         = cur_sbi;
        emit             = 1'b0;
        fmt_err          = 1'b0;
        done             = 1'b0;
        smp              = '0;

        res               = '0;
        res.kind          = KIND_HEADER;
        res.channel_count = cur_chan[1:0];
        res.sample_rate   = cur_rate;
        res.source_bits   = cur_bits;
        res.error_code    = ERR_NONE;

        unique case (cur_phase)
            PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_ID: begin
                tag_next         = tag_new;
                field_index_next = fidx_inc;
                if (fidx_inc == TAG_BYTES) begin
                    field_index_next = '0;
                    if (cur_phase == PH_RIFF_TAG) begin
                        if (tag_new != TAG_RIFF) begin
                            emit           = 1'b1;
                            fmt_err        = 1'b1;
                            res            = '0;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_NOT_RIFF;
                            res.last       = 1'b1;
                            phase_next     = PH_HALT;
                        end else begin
                            phase_next = PH_RIFF_LEN;
                        end
                    end else if (cur_phase == PH_WAVE_TAG) begin
                        if (tag_new != TAG_WAVE) begin
                            emit           = 1'b1;
                            fmt_err        = 1'b1;
                            res            = '0;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_NOT_WAVE;
                            res.last       = 1'b1;
                            phase_next     = PH_HALT;
                        end else begin
                            phase_next = PH_CHUNK_ID;
                        end
                    end else begin
                        phase_next = PH_CHUNK_LEN;
                    end
                end
            end
            PH_RIFF_LEN, PH_CHUNK_LEN: begin
                len_next         = len_new;
                field_index_next = fidx_inc;
                if (fidx_inc == TAG_BYTES) begin
                    field_index_next = '0;
                    if (cur_phase == PH_RIFF_LEN) begin
                        phase_next = PH_WAVE_TAG;
                    end else if (cur_tag == TAG_DATA) begin
                        emit = 1'b1;
                        if (cur_fmt_tag != 16'd1 || cur_chan > MAX_CHANNELS) begin
                            fmt_err        = 1'b1;
                            res            = '0;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_NOT_PCM;
                            res.last       = 1'b1;
                            phase_next     = PH_HALT;
                        end else if (cur_bits != 16'd8 && cur_bits != 16'd16 &&
                                     cur_bits != 16'd24) begin
                            fmt_err        = 1'b1;
                            res            = '0;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_BAD_DEPTH;
                            res.last       = 1'b1;
                            phase_next     = PH_HALT;
                        end else begin
                            left_next  = len_new;
                            sbi_next   = '0;
                            res.last   = empty;
                            phase_next = empty ? PH_DONE : PH_DATA;
                        end
                    end else begin
                        left_next = len_new;
                        if (len_new == '0) begin
                            phase_next = PH_CHUNK_ID;
                        end else if (cur_tag == TAG_FMT) begin
                            phase_next = PH_FMT;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
            end
            PH_FMT: begin
                case (cur_fidx)
                    5'd0:    fmt_tag_next[7:0]  = b;
                    5'd1:    fmt_tag_next[15:8] = b;
                    5'd2:    chan_next[7:0]     = b;
                    5'd3:    chan_next[15:8]    = b;
                    5'd4:    rate_next[7:0]     = b;
                    5'd5:    rate_next[15:8]    = b;
                    5'd6:    rate_next[23:16]   = b;
                    5'd7:    rate_next[31:24]   = b;
                    5'd14:   bits_next[7:0]     = b;
                    5'd15:   bits_next[15:8]    = b;
                    default: ;
                endcase
                field_index_next = fidx_inc;
                left_next        = left_dec;
                if (left_dec == '0) begin
                    field_index_next = '0;
                    phase_next       = PH_CHUNK_ID;
                end else if (fidx_inc >= FMT_CAPTURE_BYTES) begin
                    field_index_next = '0;
                    phase_next       = PH_SKIP;
                end
            end
            PH_SKIP: begin
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_CHUNK_ID;
                end
            end
            PH_DATA: begin
                left_next = left_dec;
                if (bps == 2'd1) begin
                    smp  = {b ^ PCM_OFFSET, 8'h00};
                    done = 1'b1;
                end else if (cur_sbi == 2'd0) begin
                    asm_next = b;
                    sbi_next = 2'd1;
                end else if (bps == 2'd2 || cur_sbi == 2'd2) begin
                    smp  = {b, asm_reg};
                    done = 1'b1;
                end else begin
                    asm_next = b;
                    sbi_next = 2'd2;
                end
                if (done) begin
                    emit       = 1'b1;
                    sbi_next   = '0;
                    res.kind   = KIND_SAMPLE;
                    res.sample = smp;
                    res.last   = lst;
                    if (lst) begin
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_DONE, PH_HALT: ;
            default: ;
        endcase

        if (in_data.end_of_file && !fmt_err && phase_next != PH_DONE &&
            phase_next != PH_HALT) begin
            emit           = 1'b1;
            res            = '0;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_EARLY_END;
            res.last       = 1'b1;
            phase_next     = PH_HALT;
        end

        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (step && emit) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (step) begin
            asm_reg <= asm_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_RIFF_TAG;
            tag_reg         <= '0;
            len_reg         <= '0;
            left_reg        <= '0;
            fmt_tag_reg     <= '0;
            chan_reg        <= '0;
            rate_reg        <= '0;
            bits_reg        <= '0;
            field_index_reg <= '0;
            sbi_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (step) begin
                phase_reg       <= phase_next;
                tag_reg         <= tag_next;
                len_reg         <= len_next;
                left_reg        <= left_next;
                fmt_tag_reg     <= fmt_tag_next;
                chan_reg        <= chan_next;
                rate_reg        <= rate_next;
                bits_reg        <= bits_next;
                field_index_reg <= field_index_next;
                sbi_reg         <= sbi_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    `WRP_ASSERT_NXT(a_emit_shown, aclk, aresetn, step && emit, m_valid_reg, "result dropped")
    `WRP_ASSERT_IMP(a_halt_sticky, aclk, aresetn, phase_reg == PH_HALT && !in_data.first_of_file, phase_next == PH_HALT, "left halt without restart")
    `WRP_ASSERT_IMP(a_data_depth, aclk, aresetn, phase_reg == PH_DATA, bits_reg == 16'd8 || bits_reg == 16'd16 || bits_reg == 16'd24, "data phase with bad depth")
    `WRP_ASSERT_IMP(a_fmt_index, aclk, aresetn, phase_reg == PH_FMT, field_index_reg < FMT_CAPTURE_BYTES, "fmt capture index overrun")

endmodule

/* sv/wav_riff_parser_pcm16_unit.sv */
// Top level of the WAV header parser and PCM-to-16-bit converter.
//   channel | direction | payload   | handshake
//   s_      | in        | wrp_in_t  | s_valid / s_ready
//   m_      | out       | wrp_out_t | m_valid / m_ready
// One byte per cycle sustained while the m_ side is not stalled; each byte needs one parser state update.
// A result appears in the cycle after its byte leaves the input queue.
// aresetn is synchronous, active low; first_of_file restarts the parse.
// A stalled m_ side holds the result register; the queue absorbs
// QUEUE_DEPTH bytes before s_ready drops.
module wav_riff_parser_pcm16_unit
    import wrp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  wrp_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output wrp_out_t m_data
);

    logic    q_valid;
    logic    q_ready;
    wrp_in_t q_data;

    wrp_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .q_valid(q_valid),
        .q_ready(q_ready),
        .q_data (q_data)
    );

    wrp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(q_valid),
        .in_ready(q_ready),
        .in_data (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
